[src/ebd_pkg.sv]
// Shared types, constants and helpers for the exact binary-to-decimal unit.
package ebd_pkg;

  localparam int unsigned LIMB_W = 30;
  localparam int unsigned CNT_W  = 11;

  // Input word: significand and signed power of two.
  typedef struct packed {
    logic [63:0]        mantissa;
    logic signed [11:0] exponent;
  } in_t;

  // Output word: up to two nine-digit groups, most significant first.
  typedef struct packed {
    logic [29:0] group_high;
    logic [29:0] group_low;
    logic [1:0]  groups_valid;
    logic [3:0]  lead_digits;
    logic [10:0] frac_digits;
    logic        last;
  } out_t;

  // Operation broadcast to every limb cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_MUL1,
    OP_MUL2,
    OP_MUL5,
    OP_SHIFT1,
    OP_SHIFT2
  } cell_op_t;

  // Control bundle from the sequencer to the cells.
  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  // Number of decimal digits of a limb, at least one.
  function automatic logic [3:0] digit_count(input logic [LIMB_W-1:0] x);
    logic [3:0] n;
    n = 4'd1;
    if (x >= 30'd10)        n = 4'd2;
    if (x >= 30'd100)       n = 4'd3;
    if (x >= 30'd1000)      n = 4'd4;
    if (x >= 30'd10000)     n = 4'd5;
    if (x >= 30'd100000)    n = 4'd6;
    if (x >= 30'd1000000)   n = 4'd7;
    if (x >= 30'd10000000)  n = 4'd8;
    if (x >= 30'd100000000) n = 4'd9;
    return n;
  endfunction

endpackage

[src/ebd_cell.sv]
// One base-10^9 limb cell with a carry register toward its upper neighbor.
module ebd_cell
  import ebd_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [2:0]        carry_in,
  input  logic              add_in,
  input  logic [LIMB_W-1:0] limb_nb1,
  input  logic [LIMB_W-1:0] limb_nb2,
  output logic [LIMB_W-1:0] limb_out,
  output logic [2:0]        carry_out
);

  logic [LIMB_W-1:0] limb_r;
  logic [2:0]        carry_r;
  logic [30:0]       sum;
  logic [33:0]       prod;
  logic [33:0]       sub;
  logic [33:0]       rem;
  logic [2:0]        quo;

  // Scale limb plus incoming carry by 1, 2 or 5 and split off the decimal carry.
  always_comb begin
    sum = {1'b0, limb_r} + {28'd0, carry_in};
    case (ctrl.op)
      OP_MUL2: prod = {2'd0, sum, 1'b0};
      OP_MUL5: prod = {1'b0, sum, 2'd0} + {3'd0, sum};
      default: prod = {3'd0, sum};
    endcase
    prod = prod + {33'd0, add_in};
    if (prod >= 34'd5000000000) begin
      quo = 3'd5; sub = 34'd5000000000;
    end else if (prod >= 34'd4000000000) begin
      quo = 3'd4; sub = 34'd4000000000;
    end else if (prod >= 34'd3000000000) begin
      quo = 3'd3; sub = 34'd3000000000;
    end else if (prod >= 34'd2000000000) begin
      quo = 3'd2; sub = 34'd2000000000;
    end else if (prod >= 34'd1000000000) begin
      quo = 3'd1; sub = 34'd1000000000;
    end else begin
      quo = 3'd0; sub = 34'd0;
    end
    rem = prod - sub;
  end

  // Limb and carry update.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_CLEAR: begin
        limb_r  <= '0;
        carry_r <= '0;
      end
      OP_MUL1, OP_MUL2, OP_MUL5: begin
        limb_r  <= rem[LIMB_W-1:0];
        carry_r <= quo;
      end
      OP_SHIFT1: begin
        limb_r  <= limb_nb1;
        carry_r <= '0;
      end
      OP_SHIFT2: begin
        limb_r  <= limb_nb2;
        carry_r <= '0;
      end
      default: begin
        limb_r  <= limb_r;
        carry_r <= carry_r;
      end
    endcase
  end

  assign limb_out  = limb_r;
  assign carry_out = carry_r;

endmodule

[src/exact_binary_to_decimal_unit.sv]
// Top level of the exact binary-to-decimal unit: sequencer and row of limb cells.
//
// An input word (mantissa, exponent) is taken on in_valid/in_ready and the
// exact decimal value of mantissa * 2^exponent is returned as a sequence of
// output words on out_valid/out_ready, most significant group first, up to two
// nine-digit groups per word, the final one marked by last.
// The value lives in a row of LIMBS cells, each holding one base-10^9 limb.
// In the load, scale and flush states all cells scale their limb by 1, 2
// or 5 in parallel and pass a small carry to the upper neighbor, so one
// cycle is one factor of two or five. A conversion clears the row, shifts in
// the mantissa, applies |exponent| scaling steps (the exponent saturates to
// -1074..1023), settles the carries, skips leading zero limbs and then
// emits the output words.
// One word is converted at a time; in_ready is high only when idle.
// A stalled receiver holds the output register and the emission waits.
// Reset is synchronous on rst_n and returns the sequencer to idle.
module exact_binary_to_decimal_unit
  import ebd_pkg::*;
#(
  parameter int unsigned LIMBS = 128
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int unsigned REM_W = $clog2(LIMBS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_FLUSH,
    ST_TRIM,
    ST_EMIT
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [63:0]       mant_r;
  logic              neg_r;
  logic [CNT_W-1:0]  mag_r;
  logic [3:0]        lead_r;
  logic              first_r;
  logic              out_valid_r;
  out_t              out_r;

  cell_ctrl_t        ctrl;
  logic              inject;
  logic [LIMB_W-1:0] limb   [LIMBS];
  logic [2:0]        carry  [LIMBS];
  logic              emit_go;
  logic signed [11:0] e_sat;
  logic [CNT_W-1:0]  e_mag;

  // Saturate the exponent and take its magnitude.
  always_comb begin
    e_sat = in_data.exponent;
    if (in_data.exponent < -12'sd1074) e_sat = -12'sd1074;
    if (in_data.exponent > 12'sd1023)  e_sat = 12'sd1023;
    if (e_sat[11]) e_mag = CNT_W'(-e_sat);
    else           e_mag = CNT_W'(e_sat);
  end

  assign emit_go = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  // Operation for the cell row.
  always_comb begin
    ctrl.op = OP_HOLD;
    inject  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) ctrl.op = OP_CLEAR;
      end
      ST_LOAD: begin
        ctrl.op = OP_MUL2;
        inject  = mant_r[63];
      end
      ST_SCALE: ctrl.op = neg_r ? OP_MUL5 : OP_MUL2;
      ST_FLUSH: ctrl.op = OP_MUL1;
      ST_TRIM: begin
        if (limb[LIMBS-1] == '0 && rem_r > REM_W'(1)) ctrl.op = OP_SHIFT1;
      end
      ST_EMIT: begin
        if (emit_go) ctrl.op = (rem_r >= REM_W'(2)) ? OP_SHIFT2 : OP_SHIFT1;
      end
      default: ctrl.op = OP_HOLD;
    endcase
  end

  // Row of limb cells, least significant at index 0.
  for (genvar i = 0; i < LIMBS; i++) begin : g_cell
    logic [2:0]        cin;
    logic [LIMB_W-1:0] nb1;
    logic [LIMB_W-1:0] nb2;
    if (i == 0) begin : g_lo
      assign cin = '0;
      assign nb1 = '0;
      assign nb2 = '0;
    end else if (i == 1) begin : g_l1
      assign cin = carry[i-1];
      assign nb1 = limb[i-1];
      assign nb2 = '0;
    end else begin : g_mid
      assign cin = carry[i-1];
      assign nb1 = limb[i-1];
      assign nb2 = limb[i-2];
    end
    ebd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .carry_in  (cin),
      .add_in    ((i == 0) ? inject : 1'b0),
      .limb_nb1  (nb1),
      .limb_nb2  (nb2),
      .limb_out  (limb[i]),
      .carry_out (carry[i])
    );
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rem_r       <= '0;
      first_r     <= 1'b0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            mant_r  <= in_data.mantissa;
            neg_r   <= e_sat[11];
            mag_r   <= e_mag;
            cnt_r   <= CNT_W'(63);
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          mant_r <= {mant_r[62:0], 1'b0};
          if (cnt_r == '0) begin
            if (mag_r == '0) begin
              cnt_r   <= CNT_W'(LIMBS - 1);
              state_r <= ST_FLUSH;
            end else begin
              cnt_r   <= mag_r - CNT_W'(1);
              state_r <= ST_SCALE;
            end
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_SCALE: begin
          if (cnt_r == '0) begin
            cnt_r   <= CNT_W'(LIMBS - 1);
            state_r <= ST_FLUSH;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_FLUSH: begin
          if (cnt_r == '0) begin
            rem_r   <= REM_W'(LIMBS);
            state_r <= ST_TRIM;
          end else begin
            cnt_r <= cnt_r - CNT_W'(1);
          end
        end
        ST_TRIM: begin
          if (limb[LIMBS-1] == '0 && rem_r > REM_W'(1)) begin
            rem_r <= rem_r - REM_W'(1);
          end else begin
            lead_r  <= digit_count(limb[LIMBS-1]);
            first_r <= 1'b1;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            first_r              <= 1'b0;
            out_r.group_high     <= limb[LIMBS-1];
            out_r.lead_digits    <= first_r ? lead_r : 4'd9;
            out_r.frac_digits    <= neg_r ? mag_r : '0;
            out_r.last           <= (rem_r <= REM_W'(2));
            if (rem_r >= REM_W'(2)) begin
              out_r.group_low    <= limb[LIMBS-2];
              out_r.groups_valid <= 2'd2;
              rem_r              <= rem_r - REM_W'(2);
            end else begin
              out_r.group_low    <= '0;
              out_r.groups_valid <= 2'd1;
              rem_r              <= rem_r - REM_W'(1);
            end
            if (rem_r <= REM_W'(2)) state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[test/tb.sv]
// Testbench for the exact binary-to-decimal unit: random and directed words, scoreboard check.
`timescale 1ns / 1ps
module tb;
  import ebd_pkg::*;

  localparam int MAX_LIMBS = 128;
  localparam longint unsigned RADIX = 64'd1000000000;
  localparam longint CYCLE_LIMIT = 20000000;

  // Scoreboard: computes the decimal expansion of each accepted word and checks results.
  class expansion_board;
    out_t pending[$];
    int errors;
    int shown;

    // Multiply the limb array by f, growing it with any carry.
    function void scale_limbs(ref longint unsigned limbs[MAX_LIMBS],
                              ref int count, input longint unsigned f);
      longint unsigned carry;
      longint unsigned t;
      carry = 0;
      for (int i = 0; i < count; i++) begin
        t = limbs[i] * f + carry;
        limbs[i] = t % RADIX;
        carry = t / RADIX;
      end
      while (carry > 0 && count < MAX_LIMBS) begin
        limbs[count] = carry % RADIX;
        count++;
        carry = carry / RADIX;
      end
    endfunction

    // Note an accepted input word and queue the words it should produce.
    function void note_input(in_t w);
      longint unsigned limbs[MAX_LIMBS];
      longint unsigned v;
      longint unsigned top;
      int count;
      int e;
      int k;
      int n;
      int first;
      logic [3:0] lead;
      logic [10:0] frac;
      out_t r;
      v = w.mantissa;
      e = w.exponent;
      if (e < -1074) e = -1074;
      if (e > 1023) e = 1023;
      count = 0;
      while (v > 0) begin
        limbs[count] = v % RADIX;
        count++;
        v = v / RADIX;
      end
      if (count == 0) begin
        limbs[0] = 0;
        count = 1;
      end
      frac = 0;
      if (e >= 0) begin
        k = e;
        while (k >= 29) begin
          scale_limbs(limbs, count, 64'd1 << 29);
          k -= 29;
        end
        if (k > 0) scale_limbs(limbs, count, 64'd1 << k);
      end else begin
        k = -e;
        frac = k[10:0];
        while (k >= 12) begin
          scale_limbs(limbs, count, 64'd244140625);
          k -= 12;
        end
        while (k > 0) begin
          scale_limbs(limbs, count, 64'd5);
          k--;
        end
      end
      n = count;
      while (n > 1 && limbs[n-1] == 0) n--;
      top = limbs[n-1];
      lead = 1;
      while (top >= 10 && lead < 9) begin
        top = top / 10;
        lead++;
      end
      first = 1;
      while (n > 0) begin
        r = '0;
        r.group_high = limbs[n-1][29:0];
        if (n >= 2) begin
          r.group_low = limbs[n-2][29:0];
          r.groups_valid = 2'd2;
          n -= 2;
        end else begin
          r.groups_valid = 2'd1;
          n -= 1;
        end
        r.lead_digits = first ? lead : 4'd9;
        r.frac_digits = frac;
        r.last = (n == 0);
        first = 0;
        pending.push_back(r);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word %p", got);
        end
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  expansion_board board;
  longint cycles;
  bit hold_off_request;
  bit hold_off_done;

  exact_binary_to_decimal_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle limit guard.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 200);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Offer one word and wait until it is accepted.
  task automatic send_word(logic [63:0] m, logic signed [11:0] e);
    in_t w;
    w.mantissa = m;
    w.exponent = e;
    in_data = w;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_input(w);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic idle_cycles(int n);
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [63:0] random_mantissa();
    logic [63:0] m;
    m = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: m = m >> $urandom_range(0, 63);
      1: m = m & 64'hFFFF_FFFF;
      default: ;
    endcase
    return m;
  endfunction

  // Mostly small exponents, a few at the ends and beyond the saturation points.
  function automatic logic [11:0] random_exponent();
    case ($urandom_range(0, 9))
      0: return 12'($urandom_range(0, 4095));
      1: return 12'(-1074 - int'($urandom_range(0, 947)));
      2: return 12'($urandom_range(900, 2047));
      default: return 12'(int'($urandom_range(0, 120)) - 60);
    endcase
  endfunction

  // Receiver: random stalls plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_off_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_request && !hold_off_done) begin
        out_ready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_off_done = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat (gap_length()) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
      while (cycles < CYCLE_LIMIT && $urandom_range(0, 1)) begin
        @(posedge clk);
        if (out_valid && out_ready) board.check_result(out_data);
      end
    end
  end

  // Stimulus.
  initial begin
    logic signed [11:0] edge_exps[8];
    board = new();
    hold_off_request = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    edge_exps = '{12'sd0, 12'sd1, -12'sd1, 12'sd1023, -12'sd1074, 12'sd2047, 12'sh800, 12'sd29};
    // Directed words: field extremes, zero mantissa, saturation, chunk boundaries.
    foreach (edge_exps[i]) send_word(64'hFFFF_FFFF_FFFF_FFFF, edge_exps[i]);
    send_word(64'd0, 12'sd0);
    send_word(64'd0, -12'sd5);
    send_word(64'd0, 12'sd500);
    send_word(64'd1, 12'sd0);
    send_word(64'd1, -12'sd12);
    send_word(64'd1, 12'sd58);
    send_word(64'd999999999, 12'sd0);
    send_word(64'd1000000000, 12'sd0);
    send_word(64'd1, -12'sd1074);
    send_word(64'h5555_5555_5555_5555, 12'sh555);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 12'shAAA);
    // Long receiver hold-off while words keep coming.
    hold_off_request = 1;
    repeat (4) send_word(random_mantissa(), random_exponent());
    // Pause until the scoreboard has drained.
    while (board.pending.size() != 0) @(negedge clk);
    idle_cycles(50);
    for (int i = 0; i < 120; i++) begin
      if (i % 25 == 24) idle_cycles(0);
      else if ($urandom_range(0, 3) == 0) idle_cycles(gap_length());
      send_word(random_mantissa(), random_exponent());
    end
    while (board.pending.size() != 0) @(negedge clk);
    idle_cycles(500);
    if (board.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[exact_binary_to_decimal_unit.f]
src/ebd_pkg.sv
src/ebd_cell.sv
src/exact_binary_to_decimal_unit.sv
test/tb.sv
